/* rtl/core/nmea_gga_pkg.sv */
// ----------------------------------------------------------------------------
// nmea_gga_pkg: shared types and constants for the GGA altitude parser
// Character codes, parse phases, number flags, match codes, limits and default sizes.
// ----------------------------------------------------------------------------
`default_nettype none

package nmea_gga_pkg;

  // default sizes
  localparam int unsigned LINE_CHARS_DEF   = 128;
  localparam int unsigned FIELD_CHARS_DEF  = 16;
  localparam int unsigned TALKER_CHARS_DEF = 8;

  // register reset: gga altitude field index
  localparam logic [3:0] ALT_FIELD_RESET = 4'd9;

  // character codes
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_G = 8'h47;

  // numeric limits
  localparam logic [16:0] INT_SAT    = 17'd100000;
  localparam logic [26:0] ALT_MAX_MM = 27'd99999999;
  localparam logic [4:0]  FIELD_SAT  = 5'd16;
  localparam logic [1:0]  FRAC_DIGITS_MAX = 2'd3;

  // "GGA" match progress
  localparam logic [1:0] MATCH_NONE  = 2'd0;
  localparam logic [1:0] MATCH_G     = 2'd1;
  localparam logic [1:0] MATCH_GG    = 2'd2;
  localparam logic [1:0] MATCH_FOUND = 2'd3;

  typedef enum logic [1:0] {
    PH_DOLLAR = 2'd0,
    PH_TALKER = 2'd1,
    PH_FIELDS = 2'd2,
    PH_DONE   = 2'd3
  } phase_t;

  typedef struct packed {
    logic digit;
    logic dot;
    logic bad;
  } num_flags_t;

endpackage

`default_nettype wire

/* rtl/core/nmea_gga_altitude_parser_core.sv */
// ----------------------------------------------------------------------------
// nmea_gga_altitude_parser_core: GGA sentence altitude extractor
// Parses an NMEA byte stream one beat at a time and reports the altitude of
// each GGA line in millimetres when the line's newline arrives.
// ----------------------------------------------------------------------------
// The block takes one received byte per beat and sustains one beat per clock.
// A byte is captured in an input register; in the next cycle a single pass of
// shallow logic updates the line parse state (position, phase, talker match,
// field count, decimal accumulators). On a newline that same pass loads the
// result register, so fix_valid and altitude_mm come through the input register
// and then the result register; every other byte produces no result. The only
// back-pressure is a newline that finds the result register still full and
// stalled: the byte then waits in the input register and in_stall goes high
// until the result is taken. cfg_wr_data selects which comma separated field
// holds the altitude (talker field is zero) and applies to the line in
// progress. Fraction digits past three are dropped and the value saturates at
// 99999999 mm; an absent, empty or malformed field reports invalid with zero.
`default_nettype none

module nmea_gga_altitude_parser_core
  import nmea_gga_pkg::*;
#(
  parameter int unsigned LINE_CHARS   = LINE_CHARS_DEF,
  parameter int unsigned FIELD_CHARS  = FIELD_CHARS_DEF,
  parameter int unsigned TALKER_CHARS = TALKER_CHARS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration
  input  wire logic        cfg_wr_en,
  input  wire logic [3:0]  cfg_wr_data,
  // byte input
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_rx_byte,
  // result output
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_fix_valid,
  output logic [26:0]      out_altitude_mm
);

  localparam int unsigned LPW = $clog2(LINE_CHARS);
  localparam int unsigned FCW = $clog2(FIELD_CHARS);
  localparam int unsigned TCW = $clog2(TALKER_CHARS);

  localparam logic [LPW-1:0] LINE_LAST   = LPW'(LINE_CHARS - 1);
  localparam logic [FCW-1:0] FIELD_LAST  = FCW'(FIELD_CHARS - 1);
  localparam logic [TCW-1:0] TALKER_LAST = TCW'(TALKER_CHARS - 1);

  // configuration register
  logic [3:0] alt_field_r;

  // input register
  logic       st_valid_r, st_valid_nxt;
  logic [7:0] st_byte_r, st_byte_nxt;

  // line parse state
  logic [LPW-1:0] line_pos_r, line_pos_nxt;
  logic           line_ended_r, line_ended_nxt;
  phase_t         phase_r, phase_nxt;
  logic [TCW-1:0] talk_cnt_r, talk_cnt_nxt;
  logic [1:0]     match_r, match_nxt;
  logic [4:0]     field_cnt_r, field_cnt_nxt;
  logic [FCW-1:0] fchar_cnt_r, fchar_cnt_nxt;
  logic [16:0]    int_acc_r, int_acc_nxt;
  logic [9:0]     frac_acc_r, frac_acc_nxt;
  logic [1:0]     frac_cnt_r, frac_cnt_nxt;
  num_flags_t     flags_r, flags_nxt;
  logic           lat_valid_r, lat_valid_nxt;
  logic [26:0]    lat_mm_r, lat_mm_nxt;

  // result register
  logic        out_valid_r, out_valid_nxt;
  logic        out_fix_r, out_fix_nxt;
  logic [26:0] out_mm_r, out_mm_nxt;

  // handshake control
  logic out_free;
  logic hold;
  logic proc;
  logic accept;
  logic emit;

  // altitude close: integer metres times 1000 plus scaled fraction
  logic [26:0] frac_scaled;
  logic [26:0] mm_sum;
  logic [26:0] mm_sat;

  assign out_free = !out_valid_r || !out_stall;
  // a newline needs a free result register
  assign hold     = st_valid_r && (st_byte_r == CH_LF) && !out_free;
  assign proc     = st_valid_r && !hold;
  assign in_stall = st_valid_r && hold;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    // missing fraction digits count as trailing zeros
    unique case (frac_cnt_r)
      2'd0:    frac_scaled = 27'(frac_acc_r) * 27'd1000;
      2'd1:    frac_scaled = 27'(frac_acc_r) * 27'd100;
      2'd2:    frac_scaled = 27'(frac_acc_r) * 27'd10;
      default: frac_scaled = 27'(frac_acc_r);
    endcase
    mm_sum = 27'(int_acc_r) * 27'd1000 + frac_scaled;
    mm_sat = (mm_sum > ALT_MAX_MM) ? ALT_MAX_MM : mm_sum;
  end

  // one pass of the line parser per byte
  always_comb begin
    logic [7:0]  c;
    logic        do_field;
    logic        sep;
    logic        hit;
    logic        is_digit;
    logic [19:0] int_wide;

    c        = st_byte_r;
    do_field = 1'b0;
    sep      = (c == CH_COMMA) || (c == CH_STAR);
    hit      = (field_cnt_r == {1'b0, alt_field_r});
    is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    int_wide = 20'(int_acc_r) * 20'd10 + 20'(c[3:0]);

    emit           = 1'b0;
    line_pos_nxt   = line_pos_r;
    line_ended_nxt = line_ended_r;
    phase_nxt      = phase_r;
    talk_cnt_nxt   = talk_cnt_r;
    match_nxt      = match_r;
    field_cnt_nxt  = field_cnt_r;
    fchar_cnt_nxt  = fchar_cnt_r;
    int_acc_nxt    = int_acc_r;
    frac_acc_nxt   = frac_acc_r;
    frac_cnt_nxt   = frac_cnt_r;
    flags_nxt      = flags_r;
    lat_valid_nxt  = lat_valid_r;
    lat_mm_nxt     = lat_mm_r;

    if (proc) begin
      priority if (c == CH_CR) begin
        // carriage return is not part of the line
      end else if ((c == CH_LF) || (line_pos_r >= LINE_LAST)) begin
        // newline reports; an overlong line drops this byte. both restart
        emit           = (c == CH_LF);
        line_pos_nxt   = '0;
        line_ended_nxt = 1'b0;
        phase_nxt      = PH_DOLLAR;
        talk_cnt_nxt   = '0;
        match_nxt      = MATCH_NONE;
        field_cnt_nxt  = '0;
        fchar_cnt_nxt  = '0;
        int_acc_nxt    = '0;
        frac_acc_nxt   = '0;
        frac_cnt_nxt   = '0;
        flags_nxt      = '0;
        lat_valid_nxt  = 1'b0;
        lat_mm_nxt     = '0;
      end else begin
        line_pos_nxt = line_pos_r + 1'b1;
        if (!line_ended_r && (phase_r != PH_DONE)) begin
          if (c == CH_NUL) begin
            line_ended_nxt = 1'b1;
            phase_nxt      = PH_DONE;
            lat_valid_nxt  = 1'b0;
            lat_mm_nxt     = '0;
          end else begin
            unique case (phase_r)
              PH_DOLLAR: begin
                if (c == CH_DOLLAR) begin
                  phase_nxt = PH_TALKER;
                end else begin
                  phase_nxt     = PH_DONE;
                  lat_valid_nxt = 1'b0;
                  lat_mm_nxt    = '0;
                end
              end
              PH_TALKER: begin
                if ((talk_cnt_r >= TALKER_LAST) || sep) begin
                  if (match_r != MATCH_FOUND) begin
                    phase_nxt     = PH_DONE;
                    lat_valid_nxt = 1'b0;
                    lat_mm_nxt    = '0;
                  end else begin
                    phase_nxt = PH_FIELDS;
                    do_field  = 1'b1;
                  end
                end else begin
                  talk_cnt_nxt = talk_cnt_r + 1'b1;
                  if (match_r != MATCH_FOUND) begin
                    priority if ((match_r == MATCH_GG) && (c == CH_UPPER_A)) begin
                      match_nxt = MATCH_FOUND;
                    end else if (c == CH_UPPER_G) begin
                      match_nxt = (match_r == MATCH_NONE) ? MATCH_G : MATCH_GG;
                    end else begin
                      match_nxt = MATCH_NONE;
                    end
                  end
                end
              end
              PH_FIELDS: do_field = 1'b1;
              default:   do_field = 1'b0;
            endcase
          end
        end
      end

      if (do_field) begin
        if (sep) begin
          if (hit) begin
            phase_nxt     = PH_DONE;
            lat_valid_nxt = !flags_r.bad && flags_r.digit;
            lat_mm_nxt    = (!flags_r.bad && flags_r.digit) ? mm_sat : '0;
          end else begin
            if (field_cnt_r < FIELD_SAT) begin
              field_cnt_nxt = field_cnt_r + 1'b1;
            end
            fchar_cnt_nxt = '0;
            if (c == CH_STAR) begin
              phase_nxt     = PH_DONE;
              lat_valid_nxt = 1'b0;
              lat_mm_nxt    = '0;
            end
          end
        end else if (hit && (fchar_cnt_r < FIELD_LAST)) begin
          fchar_cnt_nxt = fchar_cnt_r + 1'b1;
          if (!flags_r.bad) begin
            priority if (c == CH_DOT) begin
              if (flags_r.dot) begin
                flags_nxt.bad = 1'b1;
              end else begin
                flags_nxt.dot = 1'b1;
              end
            end else if (is_digit) begin
              flags_nxt.digit = 1'b1;
              if (!flags_r.dot) begin
                int_acc_nxt = (int_wide > 20'(INT_SAT)) ? INT_SAT : int_wide[16:0];
              end else if (frac_cnt_r < FRAC_DIGITS_MAX) begin
                frac_acc_nxt = 10'(frac_acc_r * 10'd10 + 10'(c[3:0]));
                frac_cnt_nxt = frac_cnt_r + 1'b1;
              end
            end else begin
              flags_nxt.bad = 1'b1;
            end
          end
        end
      end
    end
  end

  // input register and result register control
  always_comb begin
    st_valid_nxt = st_valid_r;
    st_byte_nxt  = st_byte_r;
    if (accept) begin
      st_valid_nxt = 1'b1;
      st_byte_nxt  = in_rx_byte;
    end else if (proc) begin
      st_valid_nxt = 1'b0;
    end

    out_valid_nxt = out_valid_r;
    out_fix_nxt   = out_fix_r;
    out_mm_nxt    = out_mm_r;
    if (emit) begin
      // only a decided valid line reports an altitude
      out_valid_nxt = 1'b1;
      out_fix_nxt   = (phase_r == PH_DONE) && lat_valid_r;
      out_mm_nxt    = ((phase_r == PH_DONE) && lat_valid_r) ? lat_mm_r : '0;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alt_field_r  <= ALT_FIELD_RESET;
      st_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      line_pos_r   <= '0;
      line_ended_r <= 1'b0;
      phase_r      <= PH_DOLLAR;
      talk_cnt_r   <= '0;
      match_r      <= MATCH_NONE;
      field_cnt_r  <= '0;
      fchar_cnt_r  <= '0;
      int_acc_r    <= '0;
      frac_acc_r   <= '0;
      frac_cnt_r   <= '0;
      flags_r      <= '0;
      lat_valid_r  <= 1'b0;
      lat_mm_r     <= '0;
    end else begin
      if (cfg_wr_en) begin
        alt_field_r <= cfg_wr_data;
      end
      st_valid_r   <= st_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      line_pos_r   <= line_pos_nxt;
      line_ended_r <= line_ended_nxt;
      phase_r      <= phase_nxt;
      talk_cnt_r   <= talk_cnt_nxt;
      match_r      <= match_nxt;
      field_cnt_r  <= field_cnt_nxt;
      fchar_cnt_r  <= fchar_cnt_nxt;
      int_acc_r    <= int_acc_nxt;
      frac_acc_r   <= frac_acc_nxt;
      frac_cnt_r   <= frac_cnt_nxt;
      flags_r      <= flags_nxt;
      lat_valid_r  <= lat_valid_nxt;
      lat_mm_r     <= lat_mm_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    st_byte_r <= st_byte_nxt;
    out_fix_r <= out_fix_nxt;
    out_mm_r  <= out_mm_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_fix_valid   = out_fix_r;
  assign out_altitude_mm = out_mm_r;

endmodule

`default_nettype wire
